// ===== design/kdlp_pkg.sv =====
package kdlp_pkg;

    // Default sizes
    localparam int NUM_KEYS_DEF    = 6;
    localparam int COUNT_WIDTH_DEF = 16;

    // Register field widths
    localparam int TICK_W    = 16;
    localparam int MASK_W    = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Register reset values
    localparam logic [TICK_W-1:0] DEBOUNCE_RST  = 16'd2;
    localparam logic [TICK_W-1:0] LONG_RST      = 16'd100;
    localparam logic [MASK_W-1:0] IDLE_MASK_RST = 6'd48;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE  = 2'd0,
        REG_LONG      = 2'd1,
        REG_IDLE_MASK = 2'd2
    } cfg_reg_t;

    // Per-key mode, as reported in key_states
    typedef enum logic [1:0] {
        MODE_RELEASED = 2'd0,
        MODE_BOUNCING = 2'd1,
        MODE_SHORT    = 2'd2,
        MODE_LONG     = 2'd3
    } key_mode_t;

    // Press thresholds handed to the key update logic
    typedef struct packed {
        logic [TICK_W-1:0] debounce_ticks;
        logic [TICK_W-1:0] long_press_ticks;
    } thresh_t;

endpackage

// ===== design/kdlp_ifs.sv =====
interface kdlp_in_if #(
    parameter int NUM_KEYS = kdlp_pkg::NUM_KEYS_DEF
);
    logic                valid;
    logic                ready;
    logic [NUM_KEYS-1:0] pin_levels;

    modport source (output valid, output pin_levels, input ready);
    modport sink   (input valid, input pin_levels, output ready);
endinterface

interface kdlp_out_if #(
    parameter int NUM_KEYS = kdlp_pkg::NUM_KEYS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [2*NUM_KEYS-1:0] key_states;

    modport source (output valid, output key_states, input ready);
    modport sink   (input valid, input key_states, output ready);
endinterface

interface kdlp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [kdlp_pkg::CFG_IDX_W-1:0] index;
    logic [kdlp_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/kdlp_key_update.sv =====
module kdlp_key_update #(
    parameter int COUNT_WIDTH = kdlp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                    pressed,
    input  kdlp_pkg::key_mode_t     mode_in,
    input  logic [COUNT_WIDTH-1:0]  count_in,
    input  kdlp_pkg::thresh_t       thresh,
    output kdlp_pkg::key_mode_t     mode_out,
    output logic [COUNT_WIDTH-1:0]  count_out
);

    localparam int CMP_W = (COUNT_WIDTH > kdlp_pkg::TICK_W) ? COUNT_WIDTH : kdlp_pkg::TICK_W;

    logic [COUNT_WIDTH-1:0] count_inc;
    logic [CMP_W-1:0]       inc_ext;
    logic                   reach_deb;
    logic                   reach_long;

    // Saturating increment and threshold compares
    assign count_inc  = (&count_in) ? count_in : count_in + COUNT_WIDTH'(1);
    assign inc_ext    = CMP_W'(count_inc);
    assign reach_deb  = inc_ext >= CMP_W'(thresh.debounce_ticks);
    assign reach_long = inc_ext >= CMP_W'(thresh.long_press_ticks);

    // Advance one key by one scan tick; release always wins
    always_comb
    begin
        mode_out  = mode_in;
        count_out = count_in;
        unique case (mode_in)
            kdlp_pkg::MODE_RELEASED:
            begin
                if (pressed)
                begin
                    count_out = count_inc;
                    mode_out  = reach_deb ? kdlp_pkg::MODE_SHORT : kdlp_pkg::MODE_BOUNCING;
                end
            end
            kdlp_pkg::MODE_BOUNCING:
            begin
                if (pressed)
                begin
                    count_out = count_inc;
                    if (reach_deb)
                    begin
                        mode_out = kdlp_pkg::MODE_SHORT;
                    end
                end
                else
                begin
                    mode_out  = kdlp_pkg::MODE_RELEASED;
                    count_out = '0;
                end
            end
            kdlp_pkg::MODE_SHORT:
            begin
                if (pressed)
                begin
                    count_out = count_inc;
                    if (reach_long)
                    begin
                        mode_out = kdlp_pkg::MODE_LONG;
                    end
                end
                else
                begin
                    mode_out  = kdlp_pkg::MODE_RELEASED;
                    count_out = '0;
                end
            end
            default:
            begin
                if (!pressed)
                begin
                    mode_out  = kdlp_pkg::MODE_RELEASED;
                    count_out = '0;
                end
            end
        endcase
    end

endmodule

// ===== design/key_debounce_long_press.sv =====
// Channel   Dir  Beat payload                    Accepted when
// key_in    in   pin_levels  [NUM_KEYS-1:0]      valid && ready
// key_out   out  key_states  [2*NUM_KEYS-1:0]    valid && ready
// cfg       in   index [1:0], data [15:0]        valid && ready (ready always high)
//
// Keys are updated one per cycle, unless the last key of a tick holds for queue
// room, through the single read port of the key-state memory, and the next tick
// starts the cycle after the last key of the previous one is read.
// Reset clears the per-key valid bits; no clearing pass, ticks are taken at once.
// Results wait in a two-entry queue; the last key of a tick holds while it has no room.
module key_debounce_long_press #(
    parameter int NUM_KEYS    = kdlp_pkg::NUM_KEYS_DEF,
    parameter int COUNT_WIDTH = kdlp_pkg::COUNT_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    kdlp_in_if.sink     key_in,
    kdlp_out_if.source  key_out,
    kdlp_cfg_if.sink    cfg
);

    localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int ENT_W = 2 + COUNT_WIDTH;
    localparam int OUT_W = 2 * NUM_KEYS;
    localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(NUM_KEYS - 1);

    // Configuration
    kdlp_pkg::thresh_t   thresh_reg;
    logic [NUM_KEYS-1:0] mask_reg;
    logic [NUM_KEYS-1:0] mask_rst;
    logic [NUM_KEYS-1:0] mask_wr;

    // Tick sequencer
    logic                busy_reg;
    logic [KEY_W-1:0]    key_idx_reg;
    logic [NUM_KEYS-1:0] pressed_reg;
    logic                is_last;
    logic                room;
    logic                issue;
    logic                accept_in;

    // Key-state memory and update stage
    logic [ENT_W-1:0]    mem [NUM_KEYS];
    logic [NUM_KEYS-1:0] vld_reg;
    logic [ENT_W-1:0]    rd_data_reg;
    logic                rd_vld_reg;
    logic                s2_valid_reg;
    logic                s2_last_reg;
    logic [KEY_W-1:0]    s2_key_reg;
    logic                s2_pressed_reg;
    logic                fwd_valid_reg;
    logic [KEY_W-1:0]    fwd_key_reg;
    logic [ENT_W-1:0]    fwd_ent_reg;
    logic [ENT_W-1:0]    ent_cur;
    logic [ENT_W-1:0]    ent_next;
    kdlp_pkg::key_mode_t mode_next;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [OUT_W-1:0]    acc_reg;
    logic [OUT_W-1:0]    acc_next;

    // Result queue
    logic [OUT_W-1:0]    q_data_reg [2];
    logic                q_wr_reg;
    logic                q_rd_reg;
    logic [1:0]          q_cnt_reg;
    logic                push;
    logic                pop;

    // Map the 6-bit mask field onto the key lanes
    for (genvar i = 0; i < NUM_KEYS; i++)
    begin : g_mask
        if (i < kdlp_pkg::MASK_W)
        begin : g_used
            assign mask_rst[i] = kdlp_pkg::IDLE_MASK_RST[i];
            assign mask_wr[i]  = cfg.data[i];
        end
        else
        begin : g_zero
            assign mask_rst[i] = 1'b0;
            assign mask_wr[i]  = 1'b0;
        end
    end

    assign cfg.ready = 1'b1;

    // Write configuration registers; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg.debounce_ticks   <= kdlp_pkg::DEBOUNCE_RST;
            thresh_reg.long_press_ticks <= kdlp_pkg::LONG_RST;
            mask_reg                    <= mask_rst;
        end
        else if (cfg.valid)
        begin
            unique case (kdlp_pkg::cfg_reg_t'(cfg.index))
                kdlp_pkg::REG_DEBOUNCE:  thresh_reg.debounce_ticks   <= cfg.data;
                kdlp_pkg::REG_LONG:      thresh_reg.long_press_ticks <= cfg.data;
                kdlp_pkg::REG_IDLE_MASK: mask_reg                    <= mask_wr;
                default: ;
            endcase
        end
    end

    // Issue keys in order; hold the last key while the queue has no room
    assign is_last = (key_idx_reg == LAST_KEY);
    assign push    = s2_valid_reg & s2_last_reg;
    assign pop     = key_out.valid & key_out.ready;
    assign room    = (3'(q_cnt_reg) + 3'(push) - 3'(pop)) < 3'd2;
    assign issue   = busy_reg & (~is_last | room);

    assign key_in.ready = ~busy_reg | (issue & is_last);
    assign accept_in    = key_in.valid & key_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            key_idx_reg <= '0;
        end
        else if (accept_in)
        begin
            busy_reg    <= 1'b1;
            key_idx_reg <= '0;
        end
        else if (issue)
        begin
            if (is_last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                key_idx_reg <= key_idx_reg + KEY_W'(1);
            end
        end
    end

    // Latch pressed flags of the accepted beat
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            pressed_reg <= key_in.pin_levels ^ mask_reg;
        end
    end

    // Key-state memory: registered read, write back from the update stage
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg <= mem[key_idx_reg];
        end
        if (s2_valid_reg)
        begin
            mem[s2_key_reg] <= ent_next;
        end
    end

    // Track written entries and the update stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_last_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= issue;
            s2_last_reg   <= issue & is_last;
            fwd_valid_reg <= s2_valid_reg;
            if (issue)
            begin
                rd_vld_reg <= vld_reg[key_idx_reg];
            end
            if (s2_valid_reg)
            begin
                vld_reg[s2_key_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s2_key_reg     <= key_idx_reg;
            s2_pressed_reg <= pressed_reg[key_idx_reg];
        end
        if (s2_valid_reg)
        begin
            fwd_key_reg <= s2_key_reg;
            fwd_ent_reg <= ent_next;
            acc_reg     <= acc_next;
        end
    end

    // Forward the write of the previous cycle; unwritten entries read as released
    always_comb
    begin
        if (fwd_valid_reg && (fwd_key_reg == s2_key_reg))
        begin
            ent_cur = fwd_ent_reg;
        end
        else if (rd_vld_reg)
        begin
            ent_cur = rd_data_reg;
        end
        else
        begin
            ent_cur = '0;
        end
    end

    kdlp_key_update #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_kdlp_key_update (
        .pressed   (s2_pressed_reg),
        .mode_in   (kdlp_pkg::key_mode_t'(ent_cur[ENT_W-1 -: 2])),
        .count_in  (ent_cur[COUNT_WIDTH-1:0]),
        .thresh    (thresh_reg),
        .mode_out  (mode_next),
        .count_out (count_next)
    );

    assign ent_next = {mode_next, count_next};

    // Place the new mode in its field of the packed result
    always_comb
    begin
        acc_next = acc_reg;
        acc_next[s2_key_reg*2 +: 2] = mode_next;
    end

    // Result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= 1'b0;
            q_rd_reg  <= 1'b0;
            q_cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                q_wr_reg <= ~q_wr_reg;
            end
            if (pop)
            begin
                q_rd_reg <= ~q_rd_reg;
            end
            q_cnt_reg <= q_cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_data_reg[q_wr_reg] <= acc_next;
        end
    end

    assign key_out.valid      = (q_cnt_reg != 2'd0);
    assign key_out.key_states = q_data_reg[q_rd_reg];

endmodule

// ===== design/kdlp_checker.sv =====
module kdlp_checker #(
    parameter int NUM_KEYS = kdlp_pkg::NUM_KEYS_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [2*NUM_KEYS-1:0] out_states
);

    logic [3:0] pending_reg;

    // Count ticks taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 4'(in_valid & in_ready) - 4'(out_valid & out_ready);
        end
    end

    // Drop results during reset
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // Every result beat has a tick behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != 4'd0))
        else $error("result without a pending tick");

    // Hold occupancy within sequencer, update stage and queue
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 4'd4)
        else $error("too many ticks in flight");

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_states))
        else $error("stalled result changed");

endmodule

bind key_debounce_long_press kdlp_checker #(
    .NUM_KEYS (NUM_KEYS)
) u_kdlp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (key_in.valid),
    .in_ready   (key_in.ready),
    .out_valid  (key_out.valid),
    .out_ready  (key_out.ready),
    .out_states (key_out.key_states)
);
